[rtl/dual_moving_average_trigger_assert.svh]
// Assertion helpers used by the checker.
`ifndef DUAL_MOVING_AVERAGE_TRIGGER_ASSERT_SVH
`define DUAL_MOVING_AVERAGE_TRIGGER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define DMAT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define DMAT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dmat_pkg.sv]
`default_nettype none
package dmat_pkg;
    localparam int SHORT_DEPTH = 8;
    localparam int LONG_DEPTH  = 32;

    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 32;
    localparam int THRESH_W   = 11;
    localparam int WINDOW_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int AVG_W      = 10;
    localparam int DIFF_W     = 11;
    localparam int DIFF_CAP   = 1024;

    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int SHORT_IDX_W = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
    localparam int LONG_IDX_W  = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
    localparam int SHORT_CNT_W = $clog2(SHORT_DEPTH + 1);
    localparam int LONG_CNT_W  = $clog2(LONG_DEPTH + 1);
    localparam int SHORT_SUM_W = $clog2(SHORT_DEPTH * SAMPLE_MAX + 1);
    localparam int LONG_SUM_W  = $clog2(LONG_DEPTH * SAMPLE_MAX + 1);

    localparam int DIV_NUM_W  = (LONG_SUM_W > SHORT_SUM_W) ? LONG_SUM_W : SHORT_SUM_W;
    localparam int DIV_DEN_W  = (LONG_CNT_W > SHORT_CNT_W) ? LONG_CNT_W : SHORT_CNT_W;
    localparam int DIV_DSH_W  = DIV_NUM_W + AVG_W - 1;
    localparam int DIV_STEP_W = $clog2(AVG_W + 1);

    localparam int IN_FIELDS_W  = SAMPLE_W + TIME_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * AVG_W + DIFF_W + 2;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(20);
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(2000);

    typedef enum logic {
        CFG_THRESHOLD = 1'b0,
        CFG_WINDOW    = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_CLEAR  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_SHORT,
        CMD_BOTH
    } t_cmd_kind;

    typedef struct packed {
        logic                  we;
        t_cfg_idx              addr;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [SAMPLE_W-1:0]   sample;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_q_ctl;

    typedef enum logic [1:0] {
        F_IDLE,
        F_ACC,
        F_CMP,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_START,
        B_DIV,
        B_OUT
    } t_back_state;
endpackage
`default_nettype wire

[rtl/dmat_front.sv]
`default_nettype none
module dmat_front import dmat_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg_wr               i_cfg,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_action,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    input  wire logic [TIME_W-1:0]     i_time_stamp,
    input  wire logic                  i_full,
    output logic                       o_push,
    output t_cmd                       o_cmd
);
    t_front_state          r_state, n_state;
    logic [WINDOW_W-1:0]   r_window;
    logic [WINDOW_W-1:0]   r_interval, n_interval;
    logic [TIME_W-1:0]     r_prev, n_prev;
    logic [TIME_W-1:0]     r_acc, n_acc;
    logic [TIME_W-1:0]     r_delta, n_delta;
    t_cmd                  r_cmd, n_cmd;
    logic [TIME_W:0]       w_over;
    logic                  w_enter;
    logic                  w_take;

    assign w_take = i_valid && (r_state == F_IDLE);
    // accumulator above interval: difference neither borrows nor is zero
    assign w_over  = {1'b0, r_acc} - {{(TIME_W + 1 - WINDOW_W){1'b0}}, r_interval};
    assign w_enter = !w_over[TIME_W] && (w_over[TIME_W-1:0] != '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = (t_action'(i_action) == ACT_CLEAR) ? F_PUSH : F_ACC;
                end
            end
            F_ACC:  n_state = F_CMP;
            F_CMP:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = (r_state == F_IDLE);
        o_push     = (r_state == F_PUSH) && !i_full;
        o_cmd      = r_cmd;
        n_interval = r_interval;
        n_prev     = r_prev;
        n_acc      = r_acc;
        n_delta    = r_delta;
        n_cmd      = r_cmd;
        case (r_state)
            F_IDLE: begin
                if (w_take) begin
                    n_cmd.sample = i_sample;
                    if (t_action'(i_action) == ACT_CLEAR) begin
                        n_cmd.kind = CMD_CLEAR;
                        n_interval = WINDOW_W'(r_window / LONG_DEPTH);
                    end else begin
                        n_cmd.kind = CMD_SHORT;
                        n_delta    = i_time_stamp - r_prev;
                        n_prev     = i_time_stamp;
                    end
                end
            end
            F_ACC: n_acc = r_acc + r_delta;
            F_CMP: begin
                if (w_enter) begin
                    n_acc      = w_over[TIME_W-1:0];
                    n_cmd.kind = CMD_BOTH;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_window   <= WINDOW_RESET;
            r_interval <= WINDOW_W'(WINDOW_RESET / LONG_DEPTH);
            r_prev     <= '0;
            r_acc      <= '0;
        end else begin
            r_state    <= n_state;
            r_interval <= n_interval;
            r_prev     <= n_prev;
            r_acc      <= n_acc;
            if (i_cfg.we && (i_cfg.addr == CFG_WINDOW)) begin
                r_window <= i_cfg.data[WINDOW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_delta <= n_delta;
        r_cmd   <= n_cmd;
    end
endmodule
`default_nettype wire

[rtl/dmat_fifo.sv]
`default_nettype none
module dmat_fifo import dmat_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_q_ctl i_ctl,
    input  wire t_cmd   i_cmd,
    output t_cmd        o_cmd,
    output logic        o_full,
    output logic        o_empty
);
    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr;
    logic [Q_PTR_W-1:0]  r_rd;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic                w_wen;
    logic                w_ren;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_wen   = i_ctl.push && !o_full;
    assign w_ren   = i_ctl.pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wen) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_ren) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wen && !w_ren) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_ren && !w_wen) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

[rtl/dmat_div.sv]
`default_nettype none
module dmat_div import dmat_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIV_NUM_W-1:0]  i_num,
    input  wire logic [DIV_DEN_W-1:0]  i_den,
    output logic                       o_busy,
    output logic [AVG_W-1:0]           o_quot
);
    // quotient fits AVG_W bits because a sum never exceeds count * max sample
    logic                    r_busy;
    logic [DIV_STEP_W-1:0]   r_step;
    logic [DIV_NUM_W-1:0]    r_rem;
    logic [DIV_DSH_W-1:0]    r_dsh;
    logic [AVG_W-1:0]        r_quot;
    logic                    w_ge;

    assign w_ge   = (DIV_DSH_W'(r_rem) >= r_dsh);
    assign o_busy = r_busy;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= (i_den != '0);
            r_step <= DIV_STEP_W'(AVG_W);
        end else if (r_busy) begin
            r_busy <= (r_step != DIV_STEP_W'(1));
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= DIV_DSH_W'(i_den) << (AVG_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh[DIV_NUM_W-1:0];
            end
            r_dsh  <= r_dsh >> 1;
            r_quot <= {r_quot[AVG_W-2:0], w_ge};
        end
    end
endmodule
`default_nettype wire

[rtl/dmat_core.sv]
`default_nettype none
module dmat_core import dmat_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cfg_wr                 i_cfg,
    input  wire t_cmd                    i_cmd,
    input  wire logic                    i_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [OUT_TDATA_W-1:0]       o_data
);
    t_back_state               r_state, n_state;
    logic [THRESH_W-1:0]       r_thresh;

    logic [SAMPLE_W-1:0]       r_sring [SHORT_DEPTH];
    logic [SHORT_IDX_W-1:0]    r_shead;
    logic [SHORT_CNT_W-1:0]    r_scnt;
    logic [SHORT_SUM_W-1:0]    r_ssum;
    logic [SAMPLE_W-1:0]       r_lring [LONG_DEPTH];
    logic [LONG_IDX_W-1:0]     r_lhead;
    logic [LONG_CNT_W-1:0]     r_lcnt;
    logic [LONG_SUM_W-1:0]     r_lsum;

    logic                      r_out_valid;
    logic [OUT_TDATA_W-1:0]    r_out_data;

    logic                      w_start;
    logic                      w_load;
    logic                      w_sbusy, w_lbusy;
    logic [AVG_W-1:0]          w_savg, w_lavg;
    logic [DIFF_W-1:0]         w_sub, w_diff;
    logic                      w_cal, w_trig;
    logic                      w_sfull, w_lfull;
    logic                      w_lpush;
    logic [SAMPLE_W-1:0]       w_sold, w_lold;

    assign w_sfull = (r_scnt == SHORT_CNT_W'(SHORT_DEPTH));
    assign w_lfull = (r_lcnt == LONG_CNT_W'(LONG_DEPTH));
    assign w_sold  = r_sring[r_shead];
    assign w_lold  = r_lring[r_lhead];
    assign w_lpush = o_pop && (i_cmd.kind == CMD_BOTH);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = B_START;
                end
            end
            B_START: n_state = B_DIV;
            B_DIV: begin
                if (!w_sbusy && !w_lbusy) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        w_start = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            B_IDLE:  o_pop   = !i_empty;
            B_START: w_start = 1'b1;
            B_OUT:   w_load  = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    dmat_div u_short_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (DIV_NUM_W'(r_ssum)),
        .i_den   (DIV_DEN_W'(r_scnt)),
        .o_busy  (w_sbusy),
        .o_quot  (w_savg)
    );

    dmat_div u_long_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (DIV_NUM_W'(r_lsum)),
        .i_den   (DIV_DEN_W'(r_lcnt)),
        .o_busy  (w_lbusy),
        .o_quot  (w_lavg)
    );

    // empty ring leaves quotient at zero, so the average is already 0
    assign w_sub  = {1'b0, w_savg} - {1'b0, w_lavg};
    always_comb begin
        if (w_savg > w_lavg) begin
            w_diff = (w_sub > DIFF_W'(DIFF_CAP)) ? DIFF_W'(DIFF_CAP) : w_sub;
        end else begin
            w_diff = '0;
        end
    end
    assign w_cal  = !w_lfull;
    assign w_trig = !w_cal && (w_diff >= r_thresh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_thresh    <= THRESH_RESET;
            r_shead     <= '0;
            r_scnt      <= '0;
            r_ssum      <= '0;
            r_lhead     <= '0;
            r_lcnt      <= '0;
            r_lsum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.we && (i_cfg.addr == CFG_THRESHOLD)) begin
                r_thresh <= i_cfg.data[THRESH_W-1:0];
            end
            if (o_pop) begin
                if (i_cmd.kind == CMD_CLEAR) begin
                    r_shead <= '0;
                    r_scnt  <= '0;
                    r_ssum  <= '0;
                    r_lhead <= '0;
                    r_lcnt  <= '0;
                    r_lsum  <= '0;
                end else begin
                    r_shead <= (r_shead == SHORT_IDX_W'(SHORT_DEPTH - 1)) ?
                               '0 : r_shead + 1'b1;
                    if (w_sfull) begin
                        r_ssum <= r_ssum - SHORT_SUM_W'(w_sold) + SHORT_SUM_W'(i_cmd.sample);
                    end else begin
                        r_scnt <= r_scnt + 1'b1;
                        r_ssum <= r_ssum + SHORT_SUM_W'(i_cmd.sample);
                    end
                    if (w_lpush) begin
                        r_lhead <= (r_lhead == LONG_IDX_W'(LONG_DEPTH - 1)) ?
                                   '0 : r_lhead + 1'b1;
                        if (w_lfull) begin
                            r_lsum <= r_lsum - LONG_SUM_W'(w_lold) +
                                      LONG_SUM_W'(i_cmd.sample);
                        end else begin
                            r_lcnt <= r_lcnt + 1'b1;
                            r_lsum <= r_lsum + LONG_SUM_W'(i_cmd.sample);
                        end
                    end
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.kind != CMD_CLEAR)) begin
            r_sring[r_shead] <= i_cmd.sample;
        end
        if (w_lpush) begin
            r_lring[r_lhead] <= i_cmd.sample;
        end
        if (w_load) begin
            r_out_data <= {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                           w_trig, w_cal, w_diff, w_lavg, w_savg};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
endmodule
`default_nettype wire

[rtl/dual_moving_average_trigger.sv]
// Force-sensor trigger: short and long moving averages of 10-bit readings.
// Input stream (s_axis): tuser = action (0 sample, 1 clear), tdata = sample
// and 32-bit timestamp. A clear empties both rings and reloads the long
// interval from the window register. Output stream (m_axis): one result per
// request with both averages, their clamped difference, calibrating and
// triggered flags.
// Config: write i_cfg_we with i_cfg_addr 0 = threshold, 1 = long window time.
// The back end forms the averages with two ten-step restoring dividers,
// which a clear leaves idle, and works on one command at a time. The front
// end takes a new request only after pushing the last one; it keeps the
// timing accumulator and feeds a 4-deep command queue, so it keeps accepting
// while the back end works, until the queue is full. A stalled output holds
// its result; the back end keeps running and only waits when a second
// result is ready before the first is taken.
// Reset (synchronous, active low) empties the rings and the queue, clears
// timestamp and accumulator, and reloads the register defaults.
`default_nettype none
module dual_moving_average_trigger import dmat_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // [9:0] sample, [41:10] time_stamp, rest zero
    input  wire logic [IN_TDATA_W-1:0]   i_s_axis_tdata,
    // [0] action
    input  wire logic                    i_s_axis_tuser,
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    // [9:0] short_average, [19:10] long_average, [30:20] difference,
    // [31] calibrating, [32] triggered, rest zero
    output logic [OUT_TDATA_W-1:0]       o_m_axis_tdata
);
    t_cfg_wr w_cfg;
    t_q_ctl  w_q;
    t_cmd    w_push_cmd;
    t_cmd    w_head_cmd;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.addr = t_cfg_idx'(i_cfg_addr);
    assign w_cfg.data = i_cfg_data;

    dmat_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_action     (i_s_axis_tuser),
        .i_sample     (i_s_axis_tdata[SAMPLE_W-1:0]),
        .i_time_stamp (i_s_axis_tdata[SAMPLE_W +: TIME_W]),
        .i_full       (w_q.full),
        .o_push       (w_q.push),
        .o_cmd        (w_push_cmd)
    );

    dmat_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_q),
        .i_cmd   (w_push_cmd),
        .o_cmd   (w_head_cmd),
        .o_full  (w_q.full),
        .o_empty (w_q.empty)
    );

    dmat_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_cmd   (w_head_cmd),
        .i_empty (w_q.empty),
        .o_pop   (w_q.pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );
endmodule
`default_nettype wire

[rtl/dmat_checker.sv]
`default_nettype none
`include "dual_moving_average_trigger_assert.svh"
module dmat_checker import dmat_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    // stalled result stays put
    `DMAT_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "output changed while stalled")
    // no trigger while the long ring is still filling
    `DMAT_ASSERT_IMP(a_trig_cal, o_m_axis_tvalid, !(o_m_axis_tdata[32] && o_m_axis_tdata[31]), "trigger during calibration")
    // difference agrees with the two averages
    `DMAT_ASSERT_IMP(a_diff, o_m_axis_tvalid, (o_m_axis_tdata[9:0] > o_m_axis_tdata[19:10]) ? (o_m_axis_tdata[30:20] == ({1'b0, o_m_axis_tdata[9:0]} - {1'b0, o_m_axis_tdata[19:10]})) : (o_m_axis_tdata[30:20] == 11'd0), "difference mismatch")
endmodule

bind dual_moving_average_trigger dmat_checker u_checker (.*);
`default_nettype wire

[dv/trigger_checker.sv]
module trigger_checker import dmat_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_axis_tvalid,
    input  logic                   i_s_axis_tready,
    // [9:0] sample, [41:10] time_stamp, rest zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] action
    input  logic                   i_s_axis_tuser,
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [9:0] short_average, [19:10] long_average, [30:20] difference,
    // [31] calibrating, [32] triggered, rest zero
    input  logic [OUT_TDATA_W-1:0] i_m_axis_tdata,
    output int                     o_mismatches,
    output int                     o_outstanding
);

    // lowest field last, so the struct lines up with the low bits of tdata
    typedef struct packed {
        logic                triggered;
        logic                calibrating;
        logic [DIFF_W-1:0]   difference;
        logic [AVG_W-1:0]    long_avg;
        logic [AVG_W-1:0]    short_avg;
    } t_verdict;

    logic [SAMPLE_W-1:0] short_win[$];
    logic [SAMPLE_W-1:0] long_win[$];
    int                  short_total;
    int                  long_total;
    logic [TIME_W-1:0]   elapsed_acc;
    logic [TIME_W-1:0]   last_stamp;
    logic [WINDOW_W-1:0] long_gap;
    logic [THRESH_W-1:0] threshold;
    logic [WINDOW_W-1:0] window;
    t_verdict            verdicts_due[$];
    int                  fails = 0;

    assign o_mismatches = fails;

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            fails++;
            if (fails <= 200)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    task automatic predict_verdict(input t_action act, input logic [SAMPLE_W-1:0] v,
                                   input logic [TIME_W-1:0] ts);
        t_verdict r;
        int       sa;
        int       la;
        if (act == ACT_CLEAR) begin
            long_gap = WINDOW_W'(window / LONG_DEPTH);
            short_win.delete();
            long_win.delete();
            short_total = 0;
            long_total = 0;
        end else begin
            // full window: oldest reading drops out of the sum
            if (short_win.size() == SHORT_DEPTH) short_total -= short_win.pop_front();
            short_win.push_back(v);
            short_total += v;
            elapsed_acc = elapsed_acc + (ts - last_stamp);
            if (elapsed_acc > TIME_W'(long_gap)) begin
                elapsed_acc = elapsed_acc - TIME_W'(long_gap);
                if (long_win.size() == LONG_DEPTH) long_total -= long_win.pop_front();
                long_win.push_back(v);
                long_total += v;
            end
            last_stamp = ts;
        end
        sa = (short_win.size() == 0) ? 0 : short_total / short_win.size();
        la = (long_win.size() == 0) ? 0 : long_total / long_win.size();
        r = '0;
        r.short_avg = AVG_W'(sa);
        r.long_avg = AVG_W'(la);
        r.difference = DIFF_W'((sa > la) ? ((sa - la > DIFF_CAP) ? DIFF_CAP : sa - la) : 0);
        r.calibrating = long_win.size() < LONG_DEPTH;
        r.triggered = !r.calibrating && (r.difference >= threshold);
        verdicts_due.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            short_win.delete();
            long_win.delete();
            verdicts_due.delete();
            short_total = 0;
            long_total = 0;
            elapsed_acc = '0;
            last_stamp = '0;
            threshold = THRESH_RESET;
            window = WINDOW_RESET;
            long_gap = WINDOW_W'(WINDOW_RESET / LONG_DEPTH);
        end else begin
            // results first: a result never belongs to a request taken at the same edge
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_verdict'(i_m_axis_tdata[OUT_FIELDS_W-1:0]);
                if (verdicts_due.size() == 0) begin
                    fails++;
                    if (fails <= 200)
                        $display("%0t: result with nothing expected, expected none, actual %h",
                                 $time, i_m_axis_tdata);
                end else begin
                    want = verdicts_due.pop_front();
                    check_field("short_average", 16'(want.short_avg), 16'(got.short_avg));
                    check_field("long_average", 16'(want.long_avg), 16'(got.long_avg));
                    check_field("difference", 16'(want.difference), 16'(got.difference));
                    check_field("calibrating", 16'(want.calibrating), 16'(got.calibrating));
                    check_field("triggered", 16'(want.triggered), 16'(got.triggered));
                    check_field("padding", 16'(0),
                                16'(i_m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]));
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_THRESHOLD: threshold = i_cfg_data[THRESH_W-1:0];
                    CFG_WINDOW:    window = i_cfg_data[WINDOW_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                predict_verdict(t_action'(i_s_axis_tuser), i_s_axis_tdata[SAMPLE_W-1:0],
                                i_s_axis_tdata[SAMPLE_W +: TIME_W]);
        end
        o_outstanding <= verdicts_due.size();
    end

endmodule

[dv/tb.sv]
module tb;
    import dmat_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic                   i_cfg_addr = 1'b0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    int                  mismatches;
    int                  outstanding;
    logic                req_taken = 1'b0;
    bit                  idling = 1'b1;
    int                  stall_left = 0;
    int                  n_sent = 0;
    logic [TIME_W-1:0]   clock_ms = '0;
    bit                  rejoin = 1'b0;
    logic [WINDOW_W-1:0] window_now = WINDOW_RESET;

    dual_moving_average_trigger uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    trigger_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) req_taken <= i_s_axis_tvalid && o_s_axis_tready;

    // result side backpressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_request(input t_action act, input logic [SAMPLE_W-1:0] smp,
                                input logic [TIME_W-1:0] ts);
        if (idling && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= act;
        i_s_axis_tdata  <= IN_TDATA_W'({ts, smp});
        do @(negedge i_clk); while (!req_taken);
        n_sent++;
    endtask

    task automatic send_sample(input int level, input int spread, input int step_max);
        int v;
        v = level + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        // a wide step after an off-timeline stamp keeps the accumulator from wrapping
        clock_ms = clock_ms + (rejoin ? 32'd8192 : $urandom_range(0, step_max));
        rejoin = 1'b0;
        send_request(ACT_SAMPLE, v[SAMPLE_W-1:0], clock_ms);
    endtask

    task automatic send_noise(input int step_max);
        case ($urandom_range(0, 7))
            0: send_request(ACT_CLEAR, SAMPLE_W'($urandom), $urandom);
            1, 2, 3: begin
                if (rejoin) begin
                    send_sample($urandom_range(0, SAMPLE_MAX), 0, step_max);
                end else begin
                    send_request(ACT_SAMPLE, SAMPLE_W'($urandom), $urandom);
                    rejoin = 1'b1;
                end
            end
            default: send_sample($urandom_range(0, SAMPLE_MAX), 0, step_max);
        endcase
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic settle;
        i_s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int                  level;
        int                  lift;
        int                  n_base;
        int                  n_burst;
        int                  step;
        int                  phase;
        int                  sel;
        logic [THRESH_W-1:0] thr;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: clear on empty rings, reading extremes, stamp behind the
        // timeline across the wrap, short ring overrun
        send_request(ACT_CLEAR, '1, '1);
        send_request(ACT_SAMPLE, '0, '0);
        clock_ms = 32'd100;
        send_request(ACT_SAMPLE, '1, clock_ms);
        send_request(ACT_SAMPLE, '1, clock_ms);
        send_request(ACT_SAMPLE, 10'h2AA, 32'hFFFF_FFF0);
        rejoin = 1'b1;
        for (int i = 0; i < 12; i++) send_sample(SAMPLE_MAX - 40 * i, 0, 70);
        send_request(ACT_CLEAR, '0, '0);

        phase = 0;
        while (n_sent < 950) begin
            settle();
            if (n_sent > 830) idling = 1'b0;

            sel = (phase < 6) ? phase : $urandom_range(0, 5);
            case (sel)
                0: thr = '0;
                1: thr = THRESH_W'(DIFF_CAP);
                2: thr = '1;
                3: thr = THRESH_W'(1);
                default: thr = THRESH_W'($urandom_range(2, 200));
            endcase
            write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
            sel = (phase < 6) ? 5 - phase : $urandom_range(0, 5);
            case (sel)
                0: window_now = '0;
                1: window_now = WINDOW_W'(31);
                2: window_now = WINDOW_W'(32);
                3: window_now = '1;
                default: window_now = WINDOW_W'($urandom_range(256, 4096));
            endcase
            write_reg(CFG_WINDOW, window_now);
            phase++;

            // baseline long enough to fill the long ring, then a level step
            send_request(ACT_CLEAR, SAMPLE_W'($urandom), $urandom);
            step = 2 * (window_now / LONG_DEPTH) + 2;
            level = $urandom_range(0, SAMPLE_MAX);
            n_base = $urandom_range(LONG_DEPTH + 4, LONG_DEPTH + 16);
            for (int i = 0; i < n_base; i++) begin
                if ($urandom_range(0, 11) == 0) send_noise(step);
                else send_sample(level, 3, step);
            end
            lift = int'($urandom_range(0, 600)) - 150;
            n_burst = $urandom_range(3, 12);
            for (int i = 0; i < n_burst; i++) begin
                if ($urandom_range(0, 11) == 0) send_noise(step);
                else send_sample(level + lift, 3, step);
            end
        end

        settle();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
